// ----- hdl/tpe_pkg.sv -----
// shared types, constants and the arctangent table for the pose exponential block
`default_nettype none
package tpe_pkg;

    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [31:0] COEF_MAX    = 32'sh7FFFFFFF;
    localparam logic signed [31:0] INT_MIN     = 32'sh80000000;
    localparam logic [31:0]        SERIES_DIV  = 32'd1610612736;
    localparam logic [63:0]        SERIES_RND  = 64'd805306368;
    localparam int                 DIV_STEPS   = 32;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] t;
        logic               flip;
    } cside_t;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] t;
        logic signed [31:0] cs;
        logic signed [31:0] sn;
        logic               series;
        logic               ovf_s;
        logic               ovf_c;
        logic               neg_s;
        logic               neg_c;
    } dside_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] q;
    } dlane_t;

    function automatic logic signed [33:0] atan_q30(input int unsigned i);
        logic signed [33:0] one;
        one = 34'sd1;
        case (i)
            0:       return 34'sd843314857;
            1:       return 34'sd497837829;
            2:       return 34'sd263043837;
            3:       return 34'sd133525159;
            4:       return 34'sd67021687;
            5:       return 34'sd33543515;
            6:       return 34'sd16775851;
            7:       return 34'sd8388437;
            8:       return 34'sd4194283;
            9:       return 34'sd2097149;
            10:      return 34'sd1048576;
            default: return (i <= 30) ? (one <<< (30 - i)) : 34'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tpe_cordic_cell.sv -----
// one rotation step of the cordic chain
`default_nettype none
module tpe_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [33:0] in_x,
    input  wire logic signed [33:0] in_y,
    input  wire logic signed [33:0] in_z,
    input  wire tpe_pkg::cside_t    in_side,
    output logic                    out_valid,
    output logic signed [33:0]      out_x,
    output logic signed [33:0]      out_y,
    output logic signed [33:0]      out_z,
    output tpe_pkg::cside_t         out_side
);

    localparam logic signed [33:0] ANGLE = tpe_pkg::atan_q30(STEP);

    logic               valid_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    tpe_pkg::cside_t    side_reg;

    always_comb
    begin
        if (in_z >= 0)
        begin
            x_next = in_x - (in_y >>> STEP);
            y_next = in_y + (in_x >>> STEP);
            z_next = in_z - ANGLE;
        end
        else
        begin
            x_next = in_x + (in_y >>> STEP);
            y_next = in_y - (in_x >>> STEP);
            z_next = in_z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ----- hdl/tpe_div_cell.sv -----
// one quotient bit of the two coefficient dividers
`default_nettype none
module tpe_div_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [31:0]     in_dvs,
    input  wire tpe_pkg::dlane_t in_s,
    input  wire tpe_pkg::dlane_t in_c,
    input  wire tpe_pkg::dside_t in_side,
    output logic                 out_valid,
    output logic [31:0]          out_dvs,
    output tpe_pkg::dlane_t      out_s,
    output tpe_pkg::dlane_t      out_c,
    output tpe_pkg::dside_t      out_side
);

    function automatic tpe_pkg::dlane_t step(input tpe_pkg::dlane_t l, input logic [31:0] d);
        logic [32:0]     r2;
        logic [32:0]     diff;
        logic            ge;
        tpe_pkg::dlane_t o;
        r2    = {l.rem, l.low[31]};
        diff  = r2 - {1'b0, d};
        ge    = (r2 >= {1'b0, d});
        o.rem = ge ? diff[31:0] : r2[31:0];
        o.low = {l.low[30:0], 1'b0};
        o.q   = {l.q[30:0], ge};
        return o;
    endfunction

    logic            valid_reg;
    logic [31:0]     dvs_reg;
    tpe_pkg::dlane_t s_reg, c_reg;
    tpe_pkg::dside_t side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg  <= in_dvs;
            s_reg    <= step(in_s, in_dvs);
            c_reg    <= step(in_c, in_dvs);
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_dvs   = dvs_reg;
    assign out_s     = s_reg;
    assign out_c     = c_reg;
    assign out_side  = side_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (s_reg.rem < dvs_reg))
        else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

// ----- hdl/twist_to_pose_exponential.sv -----
// top level: planar twist to pose exponential map, fully pipelined
`default_nettype none
// Takes one twist item per cycle while the chain is not halted and returns one pose item
// per twist, in order. The twist runs through a chain of CORDIC_STEPS rotation cells, a
// capture stage, a chain of 32 restoring-divider cells (one quotient bit each, sine and
// cosine lanes side by side), a coefficient stage, a multiplier stage and a rounding
// stage. The whole chain advances together and halts only while the output register
// holds an item that is not taken. The small-angle limit is written through
// cfg_valid/cfg_data; the user must do so only while idle, as the block does not enforce it.
module twist_to_pose_exponential #(
    parameter int CORDIC_STEPS = 30
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [29:0]   cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [95:0]   s_axis_tdata,  // twist_dx, twist_dy, twist_dtheta
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [127:0]       m_axis_tdata   // pose_x, pose_y, pose_cos, pose_sin
);

    localparam int DS = tpe_pkg::DIV_STEPS;

    logic        en;
    logic [29:0] limit_reg;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 30'd8;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    // angle folding into the cordic range
    logic signed [31:0] in_t;
    logic signed [33:0] z2, z0;
    tpe_pkg::cside_t    in_side;

    assign in_t = s_axis_tdata[95:64];
    assign z2   = {in_t[31], in_t, 1'b0};

    always_comb
    begin
        in_side.dx   = s_axis_tdata[31:0];
        in_side.dy   = s_axis_tdata[63:32];
        in_side.t    = in_t;
        in_side.flip = 1'b0;
        z0           = z2;
        if (z2 > tpe_pkg::HALF_PI_Q30)
        begin
            z0           = z2 - tpe_pkg::PI_Q30;
            in_side.flip = 1'b1;
        end
        else if (z2 < -tpe_pkg::HALF_PI_Q30)
        begin
            z0           = z2 + tpe_pkg::PI_Q30;
            in_side.flip = 1'b1;
        end
    end

    logic               cv [0:CORDIC_STEPS];
    logic signed [33:0] cx [0:CORDIC_STEPS];
    logic signed [33:0] cy [0:CORDIC_STEPS];
    logic signed [33:0] cz [0:CORDIC_STEPS];
    tpe_pkg::cside_t    cside [0:CORDIC_STEPS];

    assign cv[0]    = s_axis_tvalid;
    assign cx[0]    = tpe_pkg::GAIN_Q30;
    assign cy[0]    = '0;
    assign cz[0]    = z0;
    assign cside[0] = in_side;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        tpe_cordic_cell #(.STEP(i)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(cv[i]), .in_x(cx[i]), .in_y(cy[i]), .in_z(cz[i]),
            .in_side(cside[i]),
            .out_valid(cv[i+1]), .out_x(cx[i+1]), .out_y(cy[i+1]), .out_z(cz[i+1]),
            .out_side(cside[i+1])
        );
    end

    // capture stage: clamp, unfold, series choice, angle square
    tpe_pkg::cside_t    ce;
    logic signed [33:0] xc, yc;
    logic signed [31:0] cs_n, sn_n;
    logic [31:0]        magt_n;

    logic               a_valid_reg;
    logic signed [31:0] a_dx_reg, a_dy_reg, a_t_reg, a_cs_reg, a_sn_reg;
    logic               a_series_reg;
    logic [31:0]        a_mag_reg;
    logic [63:0]        a_t2_reg;

    assign ce = cside[CORDIC_STEPS];

    always_comb
    begin
        xc = cx[CORDIC_STEPS];
        yc = cy[CORDIC_STEPS];
        if (xc > tpe_pkg::ONE_Q30)
            xc = tpe_pkg::ONE_Q30;
        else if (xc < -tpe_pkg::ONE_Q30)
            xc = -tpe_pkg::ONE_Q30;
        if (yc > tpe_pkg::ONE_Q30)
            yc = tpe_pkg::ONE_Q30;
        else if (yc < -tpe_pkg::ONE_Q30)
            yc = -tpe_pkg::ONE_Q30;
        cs_n   = ce.flip ? -xc[31:0] : xc[31:0];
        sn_n   = ce.flip ? -yc[31:0] : yc[31:0];
        magt_n = ce.t[31] ? (~ce.t + 32'd1) : ce.t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= cv[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg     <= ce.dx;
            a_dy_reg     <= ce.dy;
            a_t_reg      <= ce.t;
            a_cs_reg     <= cs_n;
            a_sn_reg     <= sn_n;
            a_series_reg <= (ce.t == 32'sd0) || (magt_n < {2'b00, limit_reg});
            a_mag_reg    <= magt_n;
            a_t2_reg     <= magt_n * magt_n;
        end
    end

    // dividend set-up
    logic [31:0]        mag_sn, dvs0;
    logic signed [33:0] omc;
    logic [63:0]        dvd_s, dvd_c, rnd;
    tpe_pkg::dlane_t    ds0, dc0;
    tpe_pkg::dside_t    dside0;

    always_comb
    begin
        mag_sn = a_sn_reg[31] ? (~a_sn_reg + 32'd1) : a_sn_reg;
        omc    = tpe_pkg::ONE_Q30 - 34'(a_cs_reg);
        rnd    = {33'd0, a_mag_reg[31:1]};
        if (a_series_reg)
        begin
            dvs0  = tpe_pkg::SERIES_DIV;
            dvd_s = a_t2_reg + tpe_pkg::SERIES_RND;
            dvd_c = '0;
        end
        else
        begin
            dvs0  = a_mag_reg;
            dvd_s = ({32'd0, mag_sn} << 29) + rnd;
            dvd_c = ({32'd0, omc[31:0]} << 29) + rnd;
        end
        dside0.dx     = a_dx_reg;
        dside0.dy     = a_dy_reg;
        dside0.t      = a_t_reg;
        dside0.cs     = a_cs_reg;
        dside0.sn     = a_sn_reg;
        dside0.series = a_series_reg;
        dside0.ovf_s  = dvd_s[63:32] >= dvs0;
        dside0.ovf_c  = dvd_c[63:32] >= dvs0;
        dside0.neg_s  = a_sn_reg[31] ^ a_t_reg[31];
        dside0.neg_c  = a_t_reg[31];
        ds0.rem       = dside0.ovf_s ? 32'd0 : dvd_s[63:32];
        ds0.low       = dvd_s[31:0];
        ds0.q         = '0;
        dc0.rem       = dside0.ovf_c ? 32'd0 : dvd_c[63:32];
        dc0.low       = dvd_c[31:0];
        dc0.q         = '0;
    end

    logic            dv   [0:DS];
    logic [31:0]     ddvs [0:DS];
    tpe_pkg::dlane_t dls  [0:DS];
    tpe_pkg::dlane_t dlc  [0:DS];
    tpe_pkg::dside_t dsd  [0:DS];

    assign dv[0]   = a_valid_reg;
    assign ddvs[0] = dvs0;
    assign dls[0]  = ds0;
    assign dlc[0]  = dc0;
    assign dsd[0]  = dside0;

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        tpe_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(dv[k]), .in_dvs(ddvs[k]), .in_s(dls[k]), .in_c(dlc[k]),
            .in_side(dsd[k]),
            .out_valid(dv[k+1]), .out_dvs(ddvs[k+1]), .out_s(dls[k+1]), .out_c(dlc[k+1]),
            .out_side(dsd[k+1])
        );
    end

    // coefficient stage
    tpe_pkg::dside_t    de;
    logic [31:0]        qs, qc, ms, mc;
    logic signed [33:0] s_full;
    logic signed [31:0] s_n, c_n;

    logic               c_valid_reg;
    logic signed [31:0] c_dx_reg, c_dy_reg, c_cs_reg, c_sn_reg, c_s_reg, c_c_reg;

    assign de = dsd[DS];
    assign qs = dls[DS].q;
    assign qc = dlc[DS].q;

    always_comb
    begin
        s_full = tpe_pkg::ONE_Q30 - $signed({2'b00, qs});
        ms     = (de.ovf_s || qs[31]) ? 32'h7FFFFFFF : qs;
        mc     = (de.ovf_c || qc[31]) ? 32'h7FFFFFFF : qc;
        if (de.series)
        begin
            if (s_full < -34'(tpe_pkg::COEF_MAX))
                s_n = -tpe_pkg::COEF_MAX;
            else
                s_n = s_full[31:0];
            c_n = (de.t == tpe_pkg::INT_MIN) ? -tpe_pkg::COEF_MAX : de.t;
        end
        else
        begin
            s_n = de.neg_s ? -$signed(ms) : $signed(ms);
            c_n = de.neg_c ? -$signed(mc) : $signed(mc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= dv[DS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_dx_reg <= de.dx;
            c_dy_reg <= de.dy;
            c_cs_reg <= de.cs;
            c_sn_reg <= de.sn;
            c_s_reg  <= s_n;
            c_c_reg  <= c_n;
        end
    end

    // products
    logic               p_valid_reg;
    logic signed [63:0] p_xa_reg, p_xb_reg, p_ya_reg, p_yb_reg;
    logic signed [31:0] p_cs_reg, p_sn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xa_reg <= c_dx_reg * c_s_reg;
            p_xb_reg <= c_dy_reg * c_c_reg;
            p_ya_reg <= c_dx_reg * c_c_reg;
            p_yb_reg <= c_dy_reg * c_s_reg;
            p_cs_reg <= c_cs_reg;
            p_sn_reg <= c_sn_reg;
        end
    end

    // rounding, saturation and output register
    logic signed [65:0] sum_x, sum_y;
    logic signed [35:0] sh_x, sh_y;
    logic signed [31:0] px_n, py_n;

    logic               o_valid_reg;
    logic signed [31:0] o_x_reg, o_y_reg, o_cs_reg, o_sn_reg;

    always_comb
    begin
        sum_x = 66'(p_xa_reg) - 66'(p_xb_reg) + 66'sd536870912;
        sum_y = 66'(p_ya_reg) + 66'(p_yb_reg) + 66'sd536870912;
        sh_x  = sum_x[65:30];
        sh_y  = sum_y[65:30];
        if (sh_x > 36'sd2147483647)
            px_n = 32'sh7FFFFFFF;
        else if (sh_x < -36'sd2147483648)
            px_n = tpe_pkg::INT_MIN;
        else
            px_n = sh_x[31:0];
        if (sh_y > 36'sd2147483647)
            py_n = 32'sh7FFFFFFF;
        else if (sh_y < -36'sd2147483648)
            py_n = tpe_pkg::INT_MIN;
        else
            py_n = sh_y[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_x_reg  <= px_n;
            o_y_reg  <= py_n;
            o_cs_reg <= p_cs_reg;
            o_sn_reg <= p_sn_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {o_sn_reg, o_cs_reg, o_y_reg, o_x_reg};

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> m_axis_tvalid)
        else $error("chain halted without a waiting result");

    a_cos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (o_cs_reg <= 32'sd1073741824 && o_cs_reg >= -32'sd1073741824))
        else $error("cosine outside unit range");

endmodule
`default_nettype wire
